FILE: src/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared sizes, codes, word types and controller/datapath interface structs
// for the shortest-remaining-time-first tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

  localparam int MAX_PROC  = 16;
  localparam int TIME_BITS = 16;

  localparam int SLOT_W = $clog2(MAX_PROC);
  localparam int CNT_W  = $clog2(MAX_PROC + 1);

  localparam int ID_W  = 16;
  localparam int ARR_W = 16;
  localparam int REM_W = 16;

  // arrival and tick compared at the wider of the two widths
  localparam int CMP_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [ID_W-1:0]  process_id;
    logic [ARR_W-1:0] arrival_time;
    logic [REM_W-1:0] burst_time;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] chosen_id;
    logic            idle;
    logic            all_done;
    logic            load_error;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic serve;
    logic tick_end;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic table_empty;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: accepts a word; a tick word runs the slot scan and serve step
// (non-empty table) and the tick update; each result goes to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  srtf_pkg::dp_stat_t stat,
  output srtf_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_SERVE   = 3'd3;
  localparam logic [2:0] S_TICKEND = 3'd4;
  localparam logic [2:0] S_PUSH    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          if (!stat.in_is_tick) begin
            state_nxt = S_PUSH;
          end else if (stat.table_empty) begin
            state_nxt = S_TICKEND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last slot is compared this cycle
        state_nxt = S_SERVE;
      end
      S_SERVE: begin
        cmd.serve = 1'b1;
        state_nxt = S_TICKEND;
      end
      S_TICKEND: begin
        cmd.tick_end = 1'b1;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/srtf_dpath.sv
// ----------------------------------------------------------------------------
// srtf_dpath
// Slot memories, scan comparator, counters, time register, pending result
// and output register of the tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_dpath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  srtf_pkg::in_word_t  in_word,
  input  srtf_pkg::dp_cmd_t   cmd,
  output srtf_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  wire                 out_stall,
  output srtf_pkg::out_word_t out_word
);

  localparam int SLOT_W = srtf_pkg::SLOT_W;
  localparam int CNT_W  = srtf_pkg::CNT_W;
  localparam int CMP_W  = srtf_pkg::CMP_W;
  localparam int TB     = srtf_pkg::TIME_BITS;

  // slot memories
  logic [srtf_pkg::ID_W-1:0]  id_mem  [srtf_pkg::MAX_PROC];
  logic [srtf_pkg::ARR_W-1:0] arr_mem [srtf_pkg::MAX_PROC];
  logic [srtf_pkg::REM_W-1:0] rem_mem [srtf_pkg::MAX_PROC];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] active_r, active_nxt;
  logic [TB-1:0]    tick_r, tick_nxt;

  logic [SLOT_W-1:0] scan_idx_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [srtf_pkg::ARR_W-1:0] arr_rd_r;
  logic [srtf_pkg::REM_W-1:0] rem_rd_r;
  logic [srtf_pkg::ID_W-1:0]  id_rd_r;

  logic                       found_r;
  logic [SLOT_W-1:0]          best_r;
  logic [srtf_pkg::REM_W-1:0] best_rem_r;

  srtf_pkg::out_word_t res_r, res_nxt;
  srtf_pkg::out_word_t out_word_r;
  logic                out_valid_r, out_valid_nxt;

  logic              table_full;
  logic              load_ok;
  logic [SLOT_W-1:0] load_slot;
  logic              cand;
  logic              better;
  logic              finishes;

  assign table_full = (count_r == CNT_W'(srtf_pkg::MAX_PROC));
  assign load_ok    = cmd.capture && (in_word.operation == srtf_pkg::OP_LOAD) && !table_full;
  assign load_slot  = count_r[SLOT_W-1:0];

  // ready: arrived by now and still has work
  assign cand   = rd_vld_r && (CMP_W'(arr_rd_r) <= CMP_W'(tick_r)) && (rem_rd_r != '0);
  assign better = cand && (!found_r || (rem_rd_r < best_rem_r));

  // served entry runs out on this tick
  assign finishes = found_r && (best_rem_r == srtf_pkg::REM_W'(1));

  assign stat.in_is_tick  = (in_word.operation == srtf_pkg::OP_TICK);
  assign stat.table_empty = (count_r == '0);
  assign stat.scan_last   = (CNT_W'(scan_idx_r) == (count_r - CNT_W'(1)));
  assign stat.out_free    = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt     = count_r;
    active_nxt    = active_r;
    tick_nxt      = tick_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;

    if (cmd.capture && (in_word.operation == srtf_pkg::OP_LOAD)) begin
      if (table_full) begin
        res_nxt.chosen_id  = '0;
        res_nxt.idle       = 1'b0;
        res_nxt.all_done   = (active_r == '0);
        res_nxt.load_error = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (in_word.burst_time != '0) begin
          active_nxt = active_r + CNT_W'(1);
        end
        res_nxt.chosen_id  = '0;
        res_nxt.idle       = 1'b0;
        res_nxt.all_done   = (active_nxt == '0);
        res_nxt.load_error = 1'b0;
      end
    end

    if (cmd.tick_end) begin
      if (finishes) begin
        active_nxt = active_r - CNT_W'(1);
      end
      // saturate at the top of the time range
      if (tick_r != '1) begin
        tick_nxt = tick_r + TB'(1);
      end
      res_nxt.chosen_id  = found_r ? id_rd_r : '0;
      res_nxt.idle       = !found_r;
      res_nxt.all_done   = (active_nxt == '0);
      res_nxt.load_error = 1'b0;
    end

    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (load_ok) begin
      id_mem[load_slot]  <= in_word.process_id;
      arr_mem[load_slot] <= in_word.arrival_time;
    end
    if (cmd.scan_rd) begin
      arr_rd_r <= arr_mem[scan_idx_r];
    end
    if (cmd.serve) begin
      id_rd_r <= id_mem[best_r];
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      rem_mem[load_slot] <= in_word.burst_time;
    end else if (cmd.serve && found_r) begin
      rem_mem[best_r] <= best_rem_r - srtf_pkg::REM_W'(1);
    end
    if (cmd.scan_rd) begin
      rem_rd_r <= rem_mem[scan_idx_r];
    end
  end

  // scan address and compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.capture) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx_r <= scan_idx_r + SLOT_W'(1);
        end
        if (better) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_idx_r <= scan_idx_r;
    end
    if (better) begin
      best_r     <= rd_idx_r;
      best_rem_r <= rem_rd_r;
    end
    res_r <= res_nxt;
    if (cmd.push) begin
      out_word_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      active_r    <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

FILE: src/srtf_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_top
// Shortest-remaining-time-first scheduler, one tick word per time unit.
// Load word: captured, then pushed. No word is taken until the last is pushed.
// Tick word: slot scan over the N loaded entries, one slot per cycle, then
// drain, serve, tick update and push; with none loaded, tick update and push.
// Reset clears entry count, time and output valid; slot memories are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_tick_scheduler_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  srtf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  wire                 out_stall,
  output srtf_pkg::out_word_t out_word
);

  srtf_pkg::dp_cmd_t  cmd;
  srtf_pkg::dp_stat_t stat;

  srtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srtf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest-remaining-time-first tick scheduler.
// Load and tick words go in through the valid/stall input channel. A
// behavioral scheduler in the bench predicts each decision word, and every
// output word is compared field by field against the oldest prediction.
// Covers preemption, late arrivals, zero bursts, a run with no idling,
// a full table, random idling and long output back-pressure.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = srtf_pkg::MAX_PROC + 24;
  localparam int EARLY_SLOTS  = 6;
  localparam int MAX_REPORTS  = 30;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  srtf_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall = 1'b0;
  srtf_pkg::out_word_t out_word;

  srtf_tick_scheduler_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // bench copy of the scheduler state
  logic [srtf_pkg::ID_W-1:0]      slot_id      [srtf_pkg::MAX_PROC];
  logic [srtf_pkg::ARR_W-1:0]     slot_arrival [srtf_pkg::MAX_PROC];
  logic [srtf_pkg::REM_W-1:0]     slot_left    [srtf_pkg::MAX_PROC];
  int                             entries_loaded = 0;
  logic [srtf_pkg::TIME_BITS-1:0] sched_time = '0;

  srtf_pkg::out_word_t due_decisions[$];

  int error_count   = 0;
  int checked_count = 0;
  int load_count    = 0;
  int refused_count = 0;
  int tick_count    = 0;
  int idle_count    = 0;

  bit idle_en   = 1'b1;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one word to the bench scheduler and return the decision it causes.
  function automatic srtf_pkg::out_word_t decide_word(input srtf_pkg::in_word_t w);
    srtf_pkg::out_word_t r;
    int                  pick;
    int                  s;
    r = '0;
    if (w.operation == srtf_pkg::OP_LOAD) begin
      load_count++;
      if (entries_loaded >= srtf_pkg::MAX_PROC) begin
        r.load_error = 1'b1;
        refused_count++;
      end else begin
        slot_id[entries_loaded]      = w.process_id;
        slot_arrival[entries_loaded] = w.arrival_time;
        slot_left[entries_loaded]    = w.burst_time;
        entries_loaded++;
      end
    end else begin
      tick_count++;
      pick = -1;
      for (s = 0; s < entries_loaded; s++) begin
        if (slot_arrival[s] <= sched_time && slot_left[s] != '0 &&
            (pick < 0 || slot_left[s] < slot_left[pick]))
          pick = s;
      end
      if (pick < 0) begin
        r.idle = 1'b1;
        idle_count++;
      end else begin
        r.chosen_id     = slot_id[pick];
        slot_left[pick] = slot_left[pick] - 1'b1;
      end
      // hold time at its maximum
      if (sched_time != '1)
        sched_time = sched_time + 1'b1;
    end
    r.all_done = 1'b1;
    for (s = 0; s < entries_loaded; s++) begin
      if (slot_left[s] != '0)
        r.all_done = 1'b0;
    end
    return r;
  endfunction

  // Offer one word; return at the edge that accepts it with valid still high.
  task automatic send_word(input srtf_pkg::in_word_t w);
    if (idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_decisions.push_back(decide_word(w));
  endtask

  task automatic load_proc(input logic [15:0] id, input logic [15:0] arrival,
                           input logic [15:0] burst);
    srtf_pkg::in_word_t w;
    w.operation    = srtf_pkg::OP_LOAD;
    w.process_id   = id;
    w.arrival_time = arrival;
    w.burst_time   = burst;
    send_word(w);
  endtask

  // Tick fields other than the operation are don't-care; fill them at random.
  task automatic tick_once();
    srtf_pkg::in_word_t w;
    w.operation    = srtf_pkg::OP_TICK;
    w.process_id   = 16'($urandom_range(16'hFFFF));
    w.arrival_time = 16'($urandom_range(16'hFFFF));
    w.burst_time   = 16'($urandom_range(16'hFFFF));
    send_word(w);
  endtask

  task automatic random_item(input int load_pct, input int slot_cap);
    logic [15:0] arrival;
    logic [15:0] burst;
    if (entries_loaded < slot_cap && $urandom_range(99) < load_pct) begin
      arrival = sched_time + 16'($urandom_range(40));
      if ($urandom_range(3) == 0)
        arrival = 16'($urandom_range(16'hFFFF));
      burst = 16'($urandom_range(1, 60));
      if ($urandom_range(9) == 0)
        burst = '0;
      load_proc(16'($urandom_range(16'hFFFF)), arrival, burst);
    end else begin
      tick_once();
    end
  endtask

  task automatic wait_results_drained();
    while (due_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Preemption by a late arrival, zero burst, idle ticks, empty table.
  task automatic test_directed();
    tick_once();
    load_proc(16'hFFFF, 16'h0000, 16'd2);
    load_proc(16'h0001, 16'h0000, 16'd3);
    load_proc(16'h00C3, 16'd4, 16'd1);
    load_proc(16'h1234, 16'h0000, 16'h0000);
    repeat (8) tick_once();
  endtask

  task automatic test_random_early(input int count);
    repeat (count) random_item(15, EARLY_SLOTS);
  endtask

  // Tick back to back with neither side idling; the far-off entry stays parked.
  task automatic test_no_idle_run();
    load_proc(16'($urandom_range(16'hFFFF)), 16'hFFFF, 16'hFFFF);
    idle_en = 1'b0;
    repeat (60) tick_once();
    idle_en = 1'b1;
  endtask

  // Block the output long enough that the scheduler backs up into its input.
  task automatic test_output_holdoff();
    hold_req <= hold_req + 1;
    repeat (24) random_item(15, srtf_pkg::MAX_PROC + 1);
  endtask

  task automatic test_sender_pause();
    repeat (10) random_item(15, srtf_pkg::MAX_PROC + 1);
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (10) random_item(15, srtf_pkg::MAX_PROC + 1);
  endtask

  task automatic test_random_late(input int count);
    repeat (count) random_item(15, srtf_pkg::MAX_PROC + 1);
  endtask

  task automatic test_full_table();
    while (entries_loaded < srtf_pkg::MAX_PROC)
      load_proc(16'($urandom_range(16'hFFFF)), sched_time, 16'($urandom_range(1, 8)));
    load_proc(16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_proc(16'h0000, 16'h0000, 16'h0000);
    repeat (4) tick_once();
  endtask

  // Output stall: random, or held for a long stretch on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    srtf_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_decisions.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t ns: unexpected word, expected none, actual %h", $time, out_word);
      end else begin
        want = due_decisions.pop_front();
        checked_count++;
        compare_field("chosen_id", 32'(want.chosen_id), 32'(out_word.chosen_id));
        compare_field("idle", 32'(want.idle), 32'(out_word.idle));
        compare_field("all_done", 32'(want.all_done), 32'(out_word.all_done));
        compare_field("load_error", 32'(want.load_error), 32'(out_word.load_error));
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_early(200);
    test_no_idle_run();
    test_output_holdoff();
    test_sender_pause();
    test_random_late(400);
    test_full_table();

    in_valid <= 1'b0;
    wait_results_drained();

    $display("Covered %0d load words (%0d refused, table full) and %0d tick words (%0d idle),",
             load_count, refused_count, tick_count, idle_count);
    $display("a run with no idling and a long output hold; %0d words checked, %0d mismatches.",
             checked_count, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Timeout with %0d decision words outstanding", due_decisions.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
